// ===== sv/ordered_array_list_engine_assert.svh =====
// assertion macros for the ordered array list engine
`ifndef ORDERED_ARRAY_LIST_ENGINE_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define OAL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered array list engine: assertion failed");

// next-cycle implication
`define OAL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered array list engine: assertion failed");

`else

`define OAL_ASSERT_IMPL(label, clk, rst, ante, cons)
`define OAL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/oal_pkg.sv =====
// shared types and constants of the ordered array list engine
`default_nettype none

package oal_pkg;

   localparam int OAL_CAPACITY = 64;
   localparam int KEY_W        = 32;
   localparam int PAYLOAD_W    = 32;
   localparam int POS_W        = 7;
   localparam int COUNT_W      = 7;

   typedef enum logic [2:0] {
      MODE_APPEND     = 3'd0,
      MODE_INSERT     = 3'd1,
      MODE_REMOVE_KEY = 3'd2,
      MODE_REMOVE_AT  = 3'd3,
      MODE_READ       = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_POS = 2'd1,
      STATUS_NO_KEY  = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ_WAIT,
      ST_SCAN,
      ST_MOVE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

   typedef struct packed {
      mode_type             mode;
      logic [POS_W-1:0]     position;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } cmd_type;

   typedef struct packed {
      logic [KEY_W-1:0]     read_key;
      logic [PAYLOAD_W-1:0] read_payload;
      logic [COUNT_W-1:0]   entry_count;
      status_type           status;
   } res_type;

endpackage

`default_nettype wire

// ===== sv/oal_store.sv =====
// entry memory: one write and one registered read port
`default_nettype none

module oal_store import oal_pkg::*; #(
   parameter int CAPACITY = OAL_CAPACITY,
   parameter int AW       = $clog2(CAPACITY)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire entry_type     wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output entry_type          rd_data
);

   entry_type store_ff [CAPACITY];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/oal_ctrl.sv =====
// sequencer with shared address stepper and key compare
`default_nettype none
`include "ordered_array_list_engine_assert.svh"

module oal_ctrl import oal_pkg::*; #(
   parameter int CAPACITY = OAL_CAPACITY,
   parameter int AW       = $clog2(CAPACITY),
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          cmd_valid,
   output logic               cmd_ready,
   input  wire cmd_type       cmd,
   output logic               res_valid,
   input  wire logic          res_ready,
   output res_type            res,
   output logic               mem_wr_en,
   output logic [AW-1:0]      mem_wr_addr,
   output entry_type          mem_wr_data,
   output logic               mem_rd_en,
   output logic [AW-1:0]      mem_rd_addr,
   input  wire entry_type     mem_rd_data
);

   localparam int CW = (CNT_W > POS_W) ? CNT_W : POS_W;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic [AW-1:0]      src_ff, src_in;
   logic [AW-1:0]      last_ff, last_in;
   logic               pend_ff, pend_in;
   status_type         status_ff, status_in;
   entry_type          read_ff, read_in;

   logic [CW-1:0]      pos_cw;
   logic [CW-1:0]      cnt_cw;
   logic               is_full;
   logic               ins_bad;
   logic               idx_bad;
   logic               key_hit;
   logic               move_up;
   logic               walk_done;
   logic [AW-1:0]      src_step;
   logic [AW-1:0]      dst_step;

   assign pos_cw    = CW'(cmd_ff.position);
   assign cnt_cw    = CW'(count_ff);
   assign is_full   = (count_ff >= CNT_W'(CAPACITY));
   assign ins_bad   = (pos_cw > cnt_cw);
   assign idx_bad   = (pos_cw >= cnt_cw);
   // shared compare against the word coming back from the store
   assign key_hit   = pend_ff && (mem_rd_data.key == cmd_ff.key);
   assign move_up   = (cmd_ff.mode == MODE_INSERT);
   assign walk_done = (left_ff == '0) && !pend_ff;
   // shared address stepper
   assign src_step  = move_up ? (src_ff - AW'(1)) : (src_ff + AW'(1));
   assign dst_step  = move_up ? (last_ff + AW'(1)) : (last_ff - AW'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (cmd_ff.mode)
               MODE_INSERT:     state_in = (ins_bad || is_full) ? ST_RESP : ST_MOVE;
               MODE_REMOVE_KEY: state_in = (count_ff == '0) ? ST_RESP : ST_SCAN;
               MODE_REMOVE_AT:  state_in = idx_bad ? ST_RESP : ST_MOVE;
               MODE_READ:       state_in = idx_bad ? ST_RESP : ST_READ_WAIT;
               default:         state_in = ST_RESP;
            endcase
         end
         ST_READ_WAIT: state_in = ST_RESP;
         ST_SCAN: begin
            if (key_hit) begin
               state_in = ST_MOVE;
            end else if (walk_done) begin
               state_in = ST_RESP;
            end
         end
         ST_MOVE: begin
            if (walk_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and store control
   always_comb begin
      cmd_in      = cmd_ff;
      count_in    = count_ff;
      left_in     = left_ff;
      src_in      = src_ff;
      last_in     = last_ff;
      pend_in     = pend_ff;
      status_in   = status_ff;
      read_in     = read_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = dst_step;
      mem_wr_data = mem_rd_data;
      mem_rd_en   = 1'b0;
      mem_rd_addr = src_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd;
            end
         end
         ST_DECODE: begin
            status_in = STATUS_OK;
            read_in   = '0;
            pend_in   = 1'b0;
            case (cmd_ff.mode)
               MODE_APPEND: begin
                  if (is_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = AW'(count_ff);
                     mem_wr_data = '{key: cmd_ff.key, payload: cmd_ff.payload};
                     count_in    = count_ff + CNT_W'(1);
                  end
               end
               MODE_INSERT: begin
                  if (ins_bad) begin
                     status_in = STATUS_BAD_POS;
                  end else if (is_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     src_in  = AW'(count_ff - CNT_W'(1));
                     left_in = CNT_W'(cnt_cw - pos_cw);
                  end
               end
               MODE_REMOVE_KEY: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_NO_KEY;
                  end else begin
                     src_in  = '0;
                     left_in = count_ff;
                  end
               end
               MODE_REMOVE_AT: begin
                  if (idx_bad) begin
                     status_in = STATUS_BAD_POS;
                  end else begin
                     src_in  = AW'(cmd_ff.position) + AW'(1);
                     left_in = CNT_W'(cnt_cw - pos_cw - CW'(1));
                  end
               end
               MODE_READ: begin
                  if (idx_bad) begin
                     status_in = STATUS_BAD_POS;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = AW'(cmd_ff.position);
                  end
               end
               default: status_in = STATUS_BAD_POS;
            endcase
         end
         ST_READ_WAIT: read_in = mem_rd_data;
         ST_SCAN: begin
            if (key_hit) begin
               // close the gap from the matching entry upwards
               src_in  = last_ff + AW'(1);
               left_in = count_ff - CNT_W'(last_ff) - CNT_W'(1);
               pend_in = 1'b0;
            end else if (left_ff != '0) begin
               mem_rd_en = 1'b1;
               last_in   = src_ff;
               src_in    = src_ff + AW'(1);
               left_in   = left_ff - CNT_W'(1);
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  status_in = STATUS_NO_KEY;
               end
            end
         end
         ST_MOVE: begin
            if (pend_ff) begin
               mem_wr_en = 1'b1;
            end
            if (left_ff != '0) begin
               mem_rd_en = 1'b1;
               last_in   = src_ff;
               src_in    = src_step;
               left_in   = left_ff - CNT_W'(1);
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (walk_done) begin
               if (move_up) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = AW'(cmd_ff.position);
                  mem_wr_data = '{key: cmd_ff.key, payload: cmd_ff.payload};
                  count_in    = count_ff + CNT_W'(1);
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      left_ff   <= left_in;
      src_ff    <= src_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      read_ff   <= read_in;
   end

   assign cmd_ready       = (state_ff == ST_IDLE);
   assign res_valid       = (state_ff == ST_RESP);
   assign res.read_key    = read_ff.key;
   assign res.read_payload = read_ff.payload;
   assign res.entry_count = COUNT_W'(count_ff);
   assign res.status      = status_ff;

   `OAL_ASSERT_NEXT(a_accept_decodes, clock, reset, cmd_valid && cmd_ready, state_ff == ST_DECODE)
   `OAL_ASSERT_IMPL(a_write_when_busy, clock, reset, mem_wr_en, (state_ff == ST_DECODE) || (state_ff == ST_MOVE))
   `OAL_ASSERT_NEXT(a_count_held, clock, reset, (state_ff == ST_IDLE) || (state_ff == ST_RESP) || (state_ff == ST_READ_WAIT), $stable(count_ff))
   `OAL_ASSERT_IMPL(a_count_bound, clock, reset, res_valid, count_ff <= CNT_W'(CAPACITY))

endmodule

`default_nettype wire

// ===== sv/ordered_array_list_engine.sv =====
// ordered array list engine: top level with stream ports and result register
//
// keeps an ordered list of up to CAPACITY key/payload entries in a single
// memory with one write and one registered read port. each request transaction
// runs one operation (append, insert at position, remove first matching key,
// remove at index, read at index) and gives exactly one response transaction
// carrying the count after the operation and a status. a small sequencer walks
// the memory one entry per cycle, so the time an operation takes is set by the
// memory port. insert moves count - position entries up one place; remove at
// index moves the count - position - 1 entries above it down one place;
// remove by key scans up to count entries, the tail above a hit being shifted
// down like a remove at index. the block takes no new request until the
// current one has finished, but a finished response may wait in the output
// register while the next request is accepted. the memory contents are
// undefined after reset; only entries below the count are ever read.
`default_nettype none

module ordered_array_list_engine import oal_pkg::*; #(
   parameter int CAPACITY = OAL_CAPACITY
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // position[6:0], entry_key, entry_payload, zero pad
   input  wire logic [2:0]  req_tuser,   // mode
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // read_key, read_payload, entry_count[6:0], zero pad
   output logic [1:0]       rsp_tuser    // status
);

   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   cmd_type          cmd;
   logic             cmd_ready;
   logic             res_valid;
   logic             res_ready;
   res_type          res;

   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr;
   entry_type        mem_wr_data;
   logic             mem_rd_en;
   logic [AW-1:0]    mem_rd_addr;
   entry_type        mem_rd_data;

   // output register between the sequencer and the response channel
   logic             rsp_valid_ff, rsp_valid_in;
   res_type          rsp_data_ff, rsp_data_in;

   // unpack the request transaction
   assign cmd.mode     = mode_type'(req_tuser);
   assign cmd.position = req_tdata[6:0];
   assign cmd.key      = req_tdata[38:7];
   assign cmd.payload  = req_tdata[70:39];

   assign req_tready = cmd_ready;

   oal_store #(
      .CAPACITY (CAPACITY),
      .AW       (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   oal_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (req_tvalid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // the slot is free when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // pack the response transaction
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff.entry_count, rsp_data_ff.read_payload,
                        rsp_data_ff.read_key};
   assign rsp_tuser  = rsp_data_ff.status;

endmodule

`default_nettype wire
